// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and lookup functions for the charset-translating Base64 encoder.
package b64e_pkg;

   // Depth of the group queue between the front and back parts.
   localparam int unsigned QueueDepth = 2;

   // ASCII code of the padding character '='.
   localparam logic [6:0] PAD_CHAR = 7'd61;

   // Index of the last of the four characters emitted for one group.
   localparam logic [1:0] LAST_CHAR_IDX = 2'd3;

   // One completed or flushed group handed from the front to the back.
   typedef struct packed {
      logic [23:0] bits;   // Oldest byte in the high bits, missing bytes zero.
      logic [1:0]  npad;   // Number of trailing '=' characters, 0 to 2.
      logic        last;   // The group ends the message.
   } group_type;

   // ISO-8859-1 images of legacy codes 128 to 255.
   localparam logic [7:0] UPPER_MAP [0:127] = '{
      8'd199, 8'd252, 8'd233, 8'd226, 8'd228, 8'd224, 8'd229, 8'd231,
      8'd234, 8'd235, 8'd232, 8'd239, 8'd238, 8'd236, 8'd196, 8'd197,
      8'd201, 8'd230, 8'd198, 8'd244, 8'd246, 8'd242, 8'd251, 8'd249,
      8'd255, 8'd214, 8'd220, 8'd162, 8'd163, 8'd165, 8'd223, 8'd102,
      8'd225, 8'd237, 8'd243, 8'd250, 8'd241, 8'd209, 8'd97,  8'd111,
      8'd191, 8'd45,  8'd45,  8'd189, 8'd188, 8'd161, 8'd171, 8'd187,
      8'd227, 8'd245, 8'd216, 8'd248, 8'd111, 8'd79,  8'd192, 8'd195,
      8'd213, 8'd168, 8'd180, 8'd43,  8'd167, 8'd169, 8'd174, 8'd63,
      8'd105, 8'd73,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
      8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
      8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
      8'd63,  8'd63,  8'd63,  8'd167, 8'd94,  8'd63,  8'd63,  8'd223,
      8'd63,  8'd182, 8'd63,  8'd63,  8'd181, 8'd63,  8'd63,  8'd63,
      8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd177,
      8'd62,  8'd60,  8'd63,  8'd63,  8'd247, 8'd61,  8'd176, 8'd176,
      8'd46,  8'd63,  8'd63,  8'd178, 8'd179, 8'd175, 8'd63,  8'd63
   };

   // Map a legacy byte to ISO-8859-1; the lower half maps to itself.
   function automatic logic [7:0] translate(input logic [7:0] b);
      logic [7:0] r;
      if (b[7] == 1'b0) begin
         r = b;
      end else begin
         r = UPPER_MAP[b[6:0]];
      end
      return r;
   endfunction

   // Standard Base64 alphabet lookup for one sextet.
   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] r;
      logic [6:0] v7;
      v7 = {1'b0, v};
      if (v < 6'd26) begin
         r = 7'd65 + v7;
      end else if (v < 6'd52) begin
         r = 7'd97 + v7 - 7'd26;
      end else if (v < 6'd62) begin
         r = 7'd48 + v7 - 7'd52;
      end else if (v == 6'd62) begin
         r = 7'd43;
      end else begin
         r = 7'd47;
      end
      return r;
   endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front part: translates incoming bytes and gathers them into groups of three.
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // is_last
   output logic                push_valid,
   input  logic                push_ready,
   output b64e_pkg::group_type push_entry
);
   import b64e_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [7:0] byte0_ff, byte0_in;
   logic [7:0] byte1_ff, byte1_in;
   logic [7:0] mapped;
   logic       flush;
   logic       accept;

   // A request is taken whenever the queue has room for a possible group.
   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign mapped     = translate(req_tdata);
   assign flush      = (count_ff == 2'd2) || req_tlast;
   assign push_valid = req_tvalid && flush;

   // Build the group entry from the held bytes and the new one.
   always_comb begin
      push_entry.last = req_tlast;
      case (count_ff)
         2'd0: begin
            push_entry.bits = {mapped, 16'd0};
            push_entry.npad = 2'd2;
         end
         2'd1: begin
            push_entry.bits = {byte0_ff, mapped, 8'd0};
            push_entry.npad = 2'd1;
         end
         2'd2: begin
            push_entry.bits = {byte0_ff, byte1_ff, mapped};
            push_entry.npad = 2'd0;
         end
         default: begin
            push_entry.bits = 24'd0;
            push_entry.npad = 2'd0;
         end
      endcase
   end

   // Hold bytes until a group is complete or the message ends.
   always_comb begin
      count_in = count_ff;
      byte0_in = byte0_ff;
      byte1_in = byte1_ff;
      if (accept) begin
         if (flush) begin
            count_in = 2'd0;
         end else begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               byte0_in = mapped;
            end else begin
               byte1_in = mapped;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
   end

endmodule

// ===== rtl/b64e_queue.sv =====
// Short queue of groups between the front and back parts.
module b64e_queue #(
   parameter int unsigned DEPTH = b64e_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  b64e_pkg::group_type push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output b64e_pkg::group_type pop_entry
);
   import b64e_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   group_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/b64e_back.sv =====
// Back part: emits the four characters of each queued group, one per cycle while rsp_tready is high.
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop,
   input  b64e_pkg::group_type pop_entry,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [6:0] out_char, [7] zero fill
   output logic                rsp_tlast    // out_last
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic [5:0] sextet;
   logic       is_pad;

   // The output register takes a new character when it is empty or drained.
   assign load = pop_valid && (!valid_ff || rsp_tready);
   assign pop  = load && (idx_ff == LAST_CHAR_IDX);

   // Pick the sextet of the current character and decide on padding.
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = pop_entry.bits[23:18];
         2'd1:    sextet = pop_entry.bits[17:12];
         2'd2:    sextet = pop_entry.bits[11:6];
         default: sextet = pop_entry.bits[5:0];
      endcase
      is_pad = ({1'b0, idx_ff} + {1'b0, pop_entry.npad}) >= 3'd4;
   end

   // Next value of the output register and character index.
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = idx_ff + 2'd1;
         valid_in = 1'b1;
         char_in  = is_pad ? PAD_CHAR : sextet_char(sextet);
         last_in  = pop_entry.last && (idx_ff == LAST_CHAR_IDX);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/charset_translate_base64_encoder.sv =====
// Top level of the charset-translating Base64 encoder.
// Each request carries one legacy byte, which is mapped to ISO-8859-1 and
// gathered into groups of three; each full group, or a partial group closed
// by tlast, yields four Base64 characters ('=' padded) on the response side,
// with rsp_tlast on the last character of the message. A request is taken
// in any cycle the group queue has room, so bytes enter back to back; the
// back part sends one character per cycle while rsp_tready is high, so the
// output sets the sustained rate, as every three bytes become four characters.
// The first character of a group is held in the queue and then in the output
// register after the byte that closes it.
module charset_translate_base64_encoder #(
   parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] out_char, [7] zero fill
   output logic       rsp_tlast     // out_last
);
   import b64e_pkg::*;

   logic      push_valid;
   logic      push_ready;
   group_type push_entry;
   logic      pop_valid;
   logic      pop;
   group_type pop_entry;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A request that ends the message always closes a group.
   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> push_valid)
      else $error("last request did not close a group");

   // A pad that does not end the message is followed at once by another pad.
   a_pad_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tdata[6:0] == PAD_CHAR && !rsp_tlast)
      |=> (rsp_tvalid && rsp_tdata[6:0] == PAD_CHAR))
      else $error("padding sequence broken");

   // A group pushed into an empty queue is visible to the back part next cycle.
   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready && !pop_valid) |=> pop_valid)
      else $error("queued group lost");

   // The last character of a message only ever leaves with a valid response.
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.last) |=> (rsp_tvalid && rsp_tlast))
      else $error("message end not marked");

endmodule
